// ===== design/kfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kfs_pkg : shared types and constants of the keyframe sampler
// Field widths, register indexes, ease codes and the controller states.
// ---------------------------------------------------------------------------
package kfs_pkg;

  localparam int TimeW  = 32;
  localparam int ValW   = 32;
  localparam int EaseW  = 3;
  localparam int IdxW   = 6;
  localparam int CountW = 7;

  localparam logic [IdxW-1:0] RegKeyCount   = 6'd0;
  localparam logic [IdxW-1:0] RegEmptyIsOne = 6'd1;

  localparam logic [EaseW-1:0] EaseInQuad    = 3'd1;
  localparam logic [EaseW-1:0] EaseOutQuad   = 3'd2;
  localparam logic [EaseW-1:0] EaseInOutQuad = 3'd3;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic                op;
    logic [IdxW-1:0]     key_index;
    logic [TimeW-1:0]    time_value;
    logic signed [ValW-1:0] key_x;
    logic signed [ValW-1:0] key_y;
    logic signed [ValW-1:0] key_z;
    logic [EaseW-1:0]    ease_code;
  } in_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] out_x;
    logic signed [ValW-1:0] out_y;
    logic signed [ValW-1:0] out_z;
  } out_word_t;

  // one key as held by a cell
  typedef struct packed {
    logic [TimeW-1:0]       tm;
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] y;
    logic signed [ValW-1:0] z;
    logic [EaseW-1:0]       ease;
  } key_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DIV, S_EASE1, S_EASE2, S_MUL, S_MULH, S_SUM, S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== design/kfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kfs_if : valid/ready channel carrying one word
// Generic handshake with source and sink modports.
// ---------------------------------------------------------------------------
interface kfs_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/kfs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kfs_cell : one key slot of the rotating key ring
// Holds one key; each shift cycle it takes its neighbour's key (slot g
// takes slot g+1, the last slot taking slot 0), so the whole table passes slot 0 in one turn.
// A write loads the key directly when its index matches and no rotation runs.
// ---------------------------------------------------------------------------
module kfs_cell #(
  parameter int IW = 6
) (
  input  wire              clk,
  input  wire              shift,
  input  wire              wr_en,
  input  wire [IW-1:0]     wr_idx,
  input  wire [IW-1:0]     my_idx,
  input  kfs_pkg::key_t    wr_key,
  input  kfs_pkg::key_t    key_in,
  output kfs_pkg::key_t    key_out
);
  kfs_pkg::key_t key;
  always_ff @(posedge clk) begin
    if (shift) begin
      key <= key_in;
    end else if (wr_en && wr_idx == my_idx) begin
      key <= wr_key;
    end
  end
  assign key_out = key;
endmodule
`default_nettype wire

// ===== design/kfs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kfs_div : restoring divider, one quotient bit per cycle
// Computes floor(num * 2^FB / den), clamped to 2^FB by the caller.
// ---------------------------------------------------------------------------
module kfs_div #(
  parameter int FB = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire [31:0]           num,
  input  wire [31:0]           den,
  output logic                 done,
  output logic [FB:0]          quo
);
  localparam int CW = $clog2(FB + 2);
  logic [32:0]   rem;
  logic [31:0]   dv;
  logic [FB:0]   q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [32:0]   trial;

  always_comb trial = {rem[31:0], 1'b0} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // integer part first: num/den is 0 or 1 since num <= den
        busy <= 1'b1;
        cnt  <= CW'(FB);
        if (num >= den) begin
          rem <= {1'b0, num - den};
          q   <= (FB+1)'(1);
        end else begin
          rem <= {1'b0, num};
          q   <= '0;
        end
        dv <= den;
      end else if (busy) begin
        if (rem[32] || !trial[32] || rem[31]) begin
          rem <= {rem[31:0], 1'b0} - {1'b0, dv};
          q   <= {q[FB-1:0], 1'b1};
        end else begin
          rem <= {rem[31:0], 1'b0};
          q   <= {q[FB-1:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = q;
endmodule
`default_nettype wire

// ===== design/keyframe_sampler_with_easing.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// keyframe_sampler_with_easing : 3D keyframe sampler with quadratic easing
// Key table in a ring of cells; fraction by serial divide; eased lerp.
// ---------------------------------------------------------------------------
// Usage
//   in  : sink channel of in_word_t. operation 0 stores a key into slot
//         key_index (no output word); operation 1 samples at time_value.
//   out : source channel of out_word_t, one word per sample.
//   cfg : cfg_we/cfg_idx/cfg_data; 0 = key_count, 1 = empty_is_one.
// Timing
//   A write is stored at its handshake. A sample rotates the key ring
//   once through slot 0 to find the first key later than the query and
//   its predecessor, then takes one decision step. Inside a span the
//   divider runs next, then two steps of easing, one multiply, one shift
//   and one sum set the word.
//   Empty table, before-first or after-last: the word is set in the decision step.
//   One item at a time; ready is low while a sample runs and while a
//   word waits, so the next item can go in the cycle after the word leaves.
// Reset
//   Clears control state and both registers; key slots are undefined
//   until written.
// Stall
//   The result sits in the output register until taken.
// ---------------------------------------------------------------------------
module keyframe_sampler_with_easing #(
  parameter int MAX_KEYS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  kfs_if.sink                   in_ch,
  kfs_if.source                 out_ch,
  input  wire                   cfg_we,
  input  wire [kfs_pkg::IdxW-1:0] cfg_idx,
  input  wire [kfs_pkg::CountW-1:0] cfg_data
);
  localparam int FB = FRACTION_BITS;
  localparam int KW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam logic [FB:0] TOne = (FB+1)'(1) << FB;

  // configuration
  logic [kfs_pkg::CountW-1:0] key_count;
  logic                       empty_is_one;
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count    <= '0;
      empty_is_one <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == kfs_pkg::RegKeyCount)        key_count <= cfg_data;
      else if (cfg_idx == kfs_pkg::RegEmptyIsOne) empty_is_one <= cfg_data[0];
    end
  end
  logic [NW-1:0] n_keys;
  always_comb begin
    if (32'(key_count) > 32'(MAX_KEYS)) n_keys = NW'(MAX_KEYS);
    else                                 n_keys = NW'(key_count);
  end

  kfs_pkg::state_t state, state_next;
  kfs_pkg::in_word_t iw;
  assign iw = in_ch.data;

  // key ring
  logic          shift;
  kfs_pkg::key_t wr_key;
  kfs_pkg::key_t ring [MAX_KEYS];
  assign wr_key = '{tm: iw.time_value, x: iw.key_x, y: iw.key_y, z: iw.key_z,
                    ease: iw.ease_code};
  logic wr_go;
  assign wr_go = in_ch.valid && in_ch.ready && iw.op == kfs_pkg::OpWrite
                 && 32'(iw.key_index) < 32'(MAX_KEYS);

  // slots beyond the reach of key_index are never written
  genvar g;
  generate
    for (g = 0; g < MAX_KEYS; g++) begin : g_cell
      kfs_cell #(.IW(kfs_pkg::IdxW)) u_cell (
        .clk    (clk),
        .shift  (shift),
        .wr_en  (wr_go && (g < (1 << kfs_pkg::IdxW))),
        .wr_idx (iw.key_index),
        .my_idx (kfs_pkg::IdxW'(g)),
        .wr_key (wr_key),
        .key_in (ring[(g + 1) % MAX_KEYS]),
        .key_out(ring[g])
      );
    end
  endgenerate

  // scan: key at slot 0 has index scan_i
  logic [KW:0]     scan_i;
  logic [31:0]     q_time;
  logic            found;
  logic [KW:0]     sel;
  kfs_pkg::key_t   prv, cur, first_k, last_k;

  // arithmetic
  logic            div_start, div_done;
  logic [FB:0]     quo, t, te;
  logic [2*FB+3:0] sq;
  logic signed [33:0]      dx, dy, dz;
  logic signed [34+FB:0]   px, py, pz;
  kfs_pkg::out_word_t      res;
  logic            res_valid;

  kfs_div #(.FB(FB)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(q_time - prv.tm), .den(cur.tm - prv.tm),
    .done(div_done), .quo(quo)
  );

  assign in_ch.ready  = (state == kfs_pkg::S_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;
  assign shift = (state == kfs_pkg::S_SCAN);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      kfs_pkg::S_IDLE:
        if (in_ch.valid && in_ch.ready && iw.op == kfs_pkg::OpSample)
          state_next = kfs_pkg::S_SCAN;
      kfs_pkg::S_SCAN:
        if (scan_i == (KW+1)'(MAX_KEYS - 1)) state_next = kfs_pkg::S_OUT;
      kfs_pkg::S_OUT: begin
        // decide after a full turn
        if (n_keys != '0 && found && sel != '0 && q_time >= prv.tm
            && cur.tm != prv.tm) begin
          div_start  = 1'b1;
          state_next = kfs_pkg::S_DIV;
        end else if (n_keys != '0 && found && sel != '0) begin
          state_next = kfs_pkg::S_EASE1;
        end else begin
          state_next = kfs_pkg::S_IDLE;
        end
      end
      kfs_pkg::S_DIV:   if (div_done) state_next = kfs_pkg::S_EASE1;
      kfs_pkg::S_EASE1: state_next = kfs_pkg::S_EASE2;
      kfs_pkg::S_EASE2: state_next = kfs_pkg::S_MUL;
      kfs_pkg::S_MUL:   state_next = kfs_pkg::S_MULH;
      kfs_pkg::S_MULH:  state_next = kfs_pkg::S_SUM;
      kfs_pkg::S_SUM:   state_next = kfs_pkg::S_IDLE;
      default:          state_next = kfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kfs_pkg::S_IDLE;
    else     state <= state_next;
  end

  // ease operand: u = 2t - ONE in upper half of in-out
  logic [FB+1:0] ea, eb;
  logic          in_hi;
  always_comb begin
    in_hi = (t >= (TOne >> 1));
    ea = {1'b0, t};
    eb = {1'b0, t};
    case (cur.ease)
      kfs_pkg::EaseOutQuad: eb = {TOne, 1'b0} - {1'b0, t};
      kfs_pkg::EaseInOutQuad: begin
        ea = in_hi ? (FB+2)'({t, 1'b0} - {1'b0, TOne}) : (FB+2)'({t, 1'b0});
        eb = in_hi ? ({TOne, 1'b0} - ea) : ea;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      unique case (state)
        kfs_pkg::S_IDLE:
          if (in_ch.valid && in_ch.ready && iw.op == kfs_pkg::OpSample) begin
            q_time <= iw.time_value;
            scan_i <= '0;
            found  <= 1'b0;
          end
        kfs_pkg::S_SCAN: begin
          scan_i <= scan_i + 1'b1;
          if (scan_i == '0) first_k <= ring[0];
          if (scan_i == (KW+1)'(n_keys) - 1'b1) last_k <= ring[0];
          if (!found && (KW+1)'(scan_i) < (KW+1)'(n_keys)) begin
            if (q_time < ring[0].tm) begin
              found <= 1'b1;
              sel   <= scan_i;
              cur   <= ring[0];
            end else begin
              prv <= ring[0];
            end
          end
        end
        kfs_pkg::S_OUT: begin
          t <= '0;
          if (n_keys == '0) begin
            res.out_x <= empty_is_one ? 32'sh10000 : '0;
            res.out_y <= empty_is_one ? 32'sh10000 : '0;
            res.out_z <= empty_is_one ? 32'sh10000 : '0;
            res_valid <= 1'b1;
          end else if (!found || sel == '0) begin
            res.out_x <= found ? first_k.x : last_k.x;
            res.out_y <= found ? first_k.y : last_k.y;
            res.out_z <= found ? first_k.z : last_k.z;
            res_valid <= 1'b1;
          end
        end
        kfs_pkg::S_DIV:
          if (div_done) t <= (quo > TOne) ? TOne : quo;
        kfs_pkg::S_EASE1: sq <= (2*FB+4)'(ea * eb);
        kfs_pkg::S_EASE2: begin
          case (cur.ease)
            kfs_pkg::EaseInQuad, kfs_pkg::EaseOutQuad:
              te <= (FB+1)'(sq >> FB);
            kfs_pkg::EaseInOutQuad:
              te <= in_hi ? (FB+1)'(((2*FB+4)'(TOne) * (2*FB+4)'(TOne) + sq) >> (FB+1))
                          : (FB+1)'(sq >> (FB+1));
            default: te <= t;
          endcase
          dx <= 34'(cur.x) - 34'(prv.x);
          dy <= 34'(cur.y) - 34'(prv.y);
          dz <= 34'(cur.z) - 34'(prv.z);
        end
        kfs_pkg::S_MUL: begin
          px <= (35+FB)'(dx * $signed({1'b0, te}));
          py <= (35+FB)'(dy * $signed({1'b0, te}));
          pz <= (35+FB)'(dz * $signed({1'b0, te}));
        end
        kfs_pkg::S_MULH: begin
          // arithmetic shift floors toward minus infinity
          px <= px >>> FB;
          py <= py >>> FB;
          pz <= pz >>> FB;
        end
        kfs_pkg::S_SUM: begin
          res.out_x <= 32'(prv.x + 32'(px));
          res.out_y <= 32'(prv.y + 32'(py));
          res.out_z <= 32'(prv.z + 32'(pz));
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench : self-checking bench for keyframe_sampler_with_easing
// Loads key tables (mostly sorted, some scrambled), samples them under
// random idling on both channels, and checks every output word against
// an in-bench predictor of search, fraction, easing and lerp.
// ---------------------------------------------------------------------------
module testbench;

  localparam int NumKeys  = 64;
  localparam int FracBits = 16;
  localparam longint unsigned TOne = 64'd1 << FracBits;
  localparam int SettleCycles = 120;   // scan + divide + ease + sum, with margin
  localparam int CycleLimit   = 1500000;

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of the key table and registers, expected words
  // -------------------------------------------------------------------------
  class sampler_scoreboard;
    logic [kfs_pkg::TimeW-1:0]       tm [NumKeys];
    logic signed [kfs_pkg::ValW-1:0] kx [NumKeys];
    logic signed [kfs_pkg::ValW-1:0] ky [NumKeys];
    logic signed [kfs_pkg::ValW-1:0] kz [NumKeys];
    logic [kfs_pkg::EaseW-1:0]       ke [NumKeys];
    int unsigned            key_count;
    bit                     empty_one;
    kfs_pkg::out_word_t     pending[$];
    int                     errors;

    function void set_reg(logic [kfs_pkg::IdxW-1:0] idx, logic [kfs_pkg::CountW-1:0] val);
      if (idx == kfs_pkg::RegKeyCount) key_count = val;
      else if (idx == kfs_pkg::RegEmptyIsOne) empty_one = val[0];
    endfunction

    function longint unsigned eased(longint unsigned t, logic [kfs_pkg::EaseW-1:0] code);
      longint unsigned u;
      case (code)
        kfs_pkg::EaseInQuad:  return (t * t) >> FracBits;
        kfs_pkg::EaseOutQuad: return (t * (2 * TOne - t)) >> FracBits;
        kfs_pkg::EaseInOutQuad: begin
          u = 2 * t;
          if (u < TOne) return (u * u) >> (FracBits + 1);
          u = u - TOne;
          return (TOne * TOne + u * (2 * TOne - u)) >> (FracBits + 1);
        end
        default: return t;
      endcase
    endfunction

    // floor lerp; arithmetic shift rounds toward minus infinity
    function logic [kfs_pkg::ValW-1:0] blend(logic signed [kfs_pkg::ValW-1:0] a,
                                             logic signed [kfs_pkg::ValW-1:0] b,
                                             longint unsigned t);
      longint sa, d, prod;
      sa   = longint'(a);
      d    = longint'(b) - sa;
      prod = d * longint'(t);
      return kfs_pkg::ValW'(sa + (prod >>> FracBits));
    endfunction

    function void note_word(kfs_pkg::in_word_t w);
      int unsigned n, sel, prv, k;
      longint unsigned t, num, den;
      kfs_pkg::out_word_t r;
      if (w.op == kfs_pkg::OpWrite) begin
        tm[w.key_index] = w.time_value;
        kx[w.key_index] = w.key_x;
        ky[w.key_index] = w.key_y;
        kz[w.key_index] = w.key_z;
        ke[w.key_index] = w.ease_code;
        return;
      end
      n = (key_count > NumKeys) ? NumKeys : key_count;
      if (n == 0) begin
        r.out_x = empty_one ? 32'h0001_0000 : '0;
        r.out_y = r.out_x;
        r.out_z = r.out_x;
        pending.push_back(r);
        return;
      end
      sel = n;
      for (int i = n - 1; i >= 0; i--)
        if (w.time_value < tm[i]) sel = i;
      if (sel == n || sel == 0) begin
        k = (sel == n) ? n - 1 : 0;
        r.out_x = kx[k];
        r.out_y = ky[k];
        r.out_z = kz[k];
        pending.push_back(r);
        return;
      end
      prv = sel - 1;
      if (w.time_value < tm[prv]) t = 0;
      else begin
        num = w.time_value - tm[prv];
        den = tm[sel] - tm[prv];
        t = (den == 0) ? 0 : (num << FracBits) / den;
        if (t > TOne) t = TOne;
      end
      t = eased(t, ke[sel]);
      r.out_x = blend(kx[prv], kx[sel], t);
      r.out_y = blend(ky[prv], ky[sel], t);
      r.out_z = blend(kz[prv], kz[sel], t);
      pending.push_back(r);
    endfunction

    function void check_word(kfs_pkg::out_word_t got);
      kfs_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("output word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.out_x !== exp_w.out_x) begin
        $error("out_x expected %h got %h", exp_w.out_x, got.out_x); errors++;
      end
      if (got.out_y !== exp_w.out_y) begin
        $error("out_y expected %h got %h", exp_w.out_y, got.out_y); errors++;
      end
      if (got.out_z !== exp_w.out_z) begin
        $error("out_z expected %h got %h", exp_w.out_z, got.out_z); errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels, block
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [kfs_pkg::IdxW-1:0]   cfg_idx  = '0;
  logic [kfs_pkg::CountW-1:0] cfg_data = '0;
  int   idle_mode = 0;   // 0: sender 30% / receiver 63%, 1: swapped, 2: none
  longint cycles = 0;

  kfs_if #(.word_t(kfs_pkg::in_word_t))  in_ch ();
  kfs_if #(.word_t(kfs_pkg::out_word_t)) out_ch ();

  sampler_scoreboard sb = new();

  always #5 clk = ~clk;

  keyframe_sampler_with_easing i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stalls at random, per idle mode
  always @(posedge clk) begin
    case (idle_mode)
      0:       out_ch.ready <= ($urandom_range(0, 99) >= 63);
      1:       out_ch.ready <= ($urandom_range(0, 99) >= 30);
      default: out_ch.ready <= 1'b1;
    endcase
  end

  // output monitor; values read here are those before this edge's updates
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  // Valid is left high after a handshake; the next word or an idle gap
  // sets it, so it never sees two assignments in one step.
  task automatic send_word(kfs_pkg::in_word_t w);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 30 : (idle_mode == 1) ? 63 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a trailing key write may still be in hand; let the block settle
    repeat (SettleCycles) @(posedge clk);
  endtask

  // registers only change once the block has gone quiet
  task automatic write_reg(logic [kfs_pkg::IdxW-1:0] idx, logic [kfs_pkg::CountW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [kfs_pkg::ValW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic kfs_pkg::in_word_t key_word(int idx, logic [kfs_pkg::TimeW-1:0] tv);
    kfs_pkg::in_word_t w;
    w.op         = kfs_pkg::OpWrite;
    w.key_index  = kfs_pkg::IdxW'(idx);
    w.time_value = tv;
    w.key_x      = pick_value();
    w.key_y      = pick_value();
    w.key_z      = pick_value();
    w.ease_code  = kfs_pkg::EaseW'($urandom_range(0, 7));
    return w;
  endfunction

  function automatic kfs_pkg::in_word_t sample_word(logic [kfs_pkg::TimeW-1:0] tv);
    kfs_pkg::in_word_t w;
    w = key_word($urandom_range(0, 63), tv);   // payload ignored by a sample
    w.op = kfs_pkg::OpSample;
    w.time_value = tv;
    return w;
  endfunction

  // ascending times with spacing from duplicate to very wide
  task automatic load_sorted(int n);
    longint unsigned acc;
    acc = $urandom_range(0, 3) == 0 ? 64'd0 : $urandom_range(0, 1 << 20);
    for (int i = 0; i < n; i++) begin
      send_word(key_word(i, acc > 64'hffff_ffff ? 32'hffff_ffff : acc[31:0]));
      case ($urandom_range(0, 7))
        0:       acc += 0;
        1, 2:    acc += $urandom_range(1, 20);
        3, 4, 5: acc += $urandom_range(1, 1 << 20);
        default: acc += $urandom_range(1, 1 << 26);
      endcase
    end
  endtask

  // query times near key times, between them, and at the extremes
  function automatic logic [kfs_pkg::TimeW-1:0] pick_query(int n);
    int k;
    k = $urandom_range(0, (n > 0 ? n : 1) - 1);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      3: return sb.tm[k];
      4: return sb.tm[k] - 1;
      5: return sb.tm[k] + 1;
      default: return sb.tm[k] + $urandom_range(0, 1 << 22);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int n, budget, cnt;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, both fill values
    write_reg(kfs_pkg::RegKeyCount, kfs_pkg::CountW'(0));
    write_reg(kfs_pkg::RegEmptyIsOne, kfs_pkg::CountW'(0));
    send_word(sample_word(32'h0));
    send_word(sample_word(32'hffff_ffff));
    drain();
    write_reg(kfs_pkg::RegEmptyIsOne, kfs_pkg::CountW'(1));
    send_word(sample_word(32'h1234_5678));
    drain();

    // every slot gets written before any non-empty sample
    for (int i = 0; i < NumKeys; i++) begin
      kfs_pkg::in_word_t w;
      w = key_word(i, i * 1000 + 1000);
      w.ease_code = kfs_pkg::EaseW'(i % 8);
      if (i == 1) begin
        w.key_x = 32'h8000_0000; w.key_y = 32'h7fff_ffff; w.key_z = 32'hffff_ffff;
      end
      if (i == 2) begin
        w.key_x = 32'h7fff_ffff; w.key_y = 32'h8000_0000; w.key_z = 32'h0;
      end
      send_word(w);
    end
    drain();
    write_reg(kfs_pkg::RegKeyCount, kfs_pkg::CountW'(64));
    // before first, after last, on a key, inside spans with each ease
    send_word(sample_word(32'h0));
    send_word(sample_word(32'hffff_ffff));
    send_word(sample_word(32'd2000));
    for (int e = 0; e < 8; e++) send_word(sample_word(e * 1000 + 1000 + 499));
    send_word(sample_word(32'd1999));
    // scrambled slot: the out-of-order key 5 closes the span that holds the query
    send_word(key_word(5, 32'd9000));
    send_word(sample_word(32'd5500));
    // equal neighbour times: the query lands on the later equal key, with t of zero
    send_word(key_word(9, 32'd9000));
    send_word(sample_word(32'd9000));
    drain();
    write_reg(kfs_pkg::RegKeyCount, kfs_pkg::CountW'(127));   // saturates to the table size
    send_word(sample_word(32'd30500));
    drain();

    // random phases: mostly sorted tables with random content
    for (int ph = 0; ph < 15; ph++) begin
      idle_mode = ph / 5;
      case (ph)
        0:  cnt = 0;
        1:  cnt = 1;
        2:  cnt = 2;
        3:  cnt = 64;
        4:  cnt = 65;
        5:  cnt = 127;
        default: cnt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                 : $urandom_range(2, 12);
      endcase
      drain();
      write_reg(kfs_pkg::RegKeyCount, kfs_pkg::CountW'(cnt));
      write_reg(kfs_pkg::RegEmptyIsOne, kfs_pkg::CountW'($urandom_range(0, 1)));
      n = cnt > NumKeys ? NumKeys : cnt;
      budget = 88;
      if ($urandom_range(0, 4) != 0) begin
        load_sorted(n);
        budget -= n;
      end
      while (budget > 0) begin
        if (ph == 7 && budget == 10)
          // hold off until the block has returned every word
          while (sb.pending.size() != 0) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
          end
        if ($urandom_range(0, 9) == 0)
          send_word(key_word($urandom_range(0, 63), $urandom));
        else
          send_word(sample_word(pick_query(n)));
        budget--;
      end
    end

    drain();
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
design/kfs_pkg.sv
design/kfs_if.sv
design/kfs_cell.sv
design/kfs_div.sv
design/keyframe_sampler_with_easing.sv
verif/testbench.sv
